[rtl/mcd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared codes, widths and types of the multi-car elevator dispatcher.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // field widths
  localparam int FLOOR_W = 4;
  localparam int CAR_W   = 2;
  localparam int FIU_W   = 5;
  localparam int SCORE_W = 6;
  localparam int CNT_W   = 6;

  // reset value of the served floor count
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd10;

  // request codes
  localparam logic [1:0] REQ_HALL  = 2'd0;
  localparam logic [1:0] REQ_CABIN = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // heading codes (hall call directions use the same up and down codes)
  localparam logic [1:0] HEAD_UP   = 2'd0;
  localparam logic [1:0] HEAD_DOWN = 2'd1;
  localparam logic [1:0] HEAD_IDLE = 2'd2;

  // stop kind of a cabin call, the bit within a floor's group of three
  localparam logic [1:0] KIND_CABIN = 2'd2;

  // report kinds
  localparam logic RPT_ACK    = 1'b0;
  localparam logic RPT_STATUS = 1'b1;

  // car update produced by the car logic
  typedef struct packed {
    logic [FLOOR_W-1:0] pos;
    logic [1:0]         motion;
    logic [2:0]         served;
    logic               nop;
  } car_upd_t;

endpackage
`default_nettype wire

[rtl/mcd_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_req_if
// Request channel: hall calls, cabin calls and time ticks.
// ----------------------------------------------------------------------------
interface mcd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] floor;
  logic [1:0] hall_direction;
  logic [2:0] car_select;

  modport source (
    output valid, req_type, floor, hall_direction, car_select,
    input  ready
  );

  modport sink (
    input  valid, req_type, floor, hall_direction, car_select,
    output ready
  );
endinterface
`default_nettype wire

[rtl/mcd_rpt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_rpt_if
// Report channel: request acknowledges and per-car status after a tick.
// ----------------------------------------------------------------------------
interface mcd_rpt_if;
  logic       valid;
  logic       ready;
  logic       report_kind;
  logic       accepted;
  logic       no_op;
  logic [1:0] car_index;
  logic [3:0] car_floor_now;
  logic [1:0] car_heading;
  logic [2:0] served_kinds;
  logic [5:0] pending_stops_count;
  logic       last_of_run;

  modport source (
    output valid, report_kind, accepted, no_op, car_index, car_floor_now,
           car_heading, served_kinds, pending_stops_count, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, report_kind, accepted, no_op, car_index, car_floor_now,
           car_heading, served_kinds, pending_stops_count, last_of_run,
    output ready
  );
endinterface
`default_nettype wire

[rtl/mcd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcd_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/mcd_car_logic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_car_logic
// Per-car read-modify-write logic: tick step with LOOK heading, stop insert
// and hall call score.
// ----------------------------------------------------------------------------
module mcd_car_logic #(
  parameter int FLOOR_LIMIT = 16
) (
  input  wire logic [mcd_pkg::FLOOR_W-1:0]   pos_i,
  input  wire logic [1:0]                    motion_i,
  input  wire logic [FLOOR_LIMIT-1:0][2:0]   mask_i,
  input  wire logic [mcd_pkg::FLOOR_W-1:0]   floor_i,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [mcd_pkg::FIU_W-1:0]     floors_i,
  output mcd_pkg::car_upd_t                  tick_o,
  output logic      [FLOOR_LIMIT-1:0][2:0]   tick_mask_o,
  output mcd_pkg::car_upd_t                  add_o,
  output logic      [FLOOR_LIMIT-1:0][2:0]   add_mask_o,
  output logic      [mcd_pkg::SCORE_W-1:0]   score_o
);
  import mcd_pkg::*;

  localparam int FIDX_W = $clog2(FLOOR_LIMIT);
  localparam logic [FLOOR_W-1:0] TOP_FLOOR = FLOOR_W'(FLOOR_LIMIT - 1);

  // LOOK heading from the stops above and below the car
  function automatic logic [1:0] next_heading(
    input logic [FLOOR_W-1:0]         pos,
    input logic [FLOOR_LIMIT-1:0][2:0] mask,
    input logic [1:0]                 motion
  );
    logic above;
    logic below;
    logic any;
    logic [1:0] head;
    above = 1'b0;
    below = 1'b0;
    any   = 1'b0;
    for (int f = 0; f < FLOOR_LIMIT; f++) begin
      if (|mask[f]) begin
        any = 1'b1;
        if (FLOOR_W'(f) > pos) above = 1'b1;
        if (FLOOR_W'(f) < pos) below = 1'b1;
      end
    end
    if (!any) begin
      head = HEAD_IDLE;
    end else if (motion == HEAD_DOWN) begin
      head = below ? HEAD_DOWN : (above ? HEAD_UP : HEAD_IDLE);
    end else begin
      head = above ? HEAD_UP : (below ? HEAD_DOWN : HEAD_IDLE);
    end
    return head;
  endfunction

  logic                         go_up;
  logic                         go_dn;
  logic [FLOOR_W-1:0]           npos;
  logic [FIDX_W-1:0]            nidx;
  logic [2:0]                   here;
  logic [2:0]                   served;
  logic [FLOOR_LIMIT-1:0][2:0]  tmask;

  // tick step: move one floor, serve stops, pick heading again; a car with no stops goes idle
  always_comb begin
    go_up  = (motion_i == HEAD_UP) && (pos_i < TOP_FLOOR);
    go_dn  = (motion_i == HEAD_DOWN) && (pos_i != '0);
    npos   = go_up ? pos_i + FLOOR_W'(1) : (go_dn ? pos_i - FLOOR_W'(1) : pos_i);
    nidx   = npos[FIDX_W-1:0];
    here   = mask_i[nidx];
    served = {here[2], (motion_i == HEAD_DOWN) & here[1], (motion_i == HEAD_UP) & here[0]};
    tmask  = mask_i;
    tick_o = '0;
    if (mask_i == '0) begin
      tick_o.pos    = pos_i;
      tick_o.motion = HEAD_IDLE;
    end else begin
      tmask[nidx]   = here & ~served;
      tick_o.pos    = npos;
      tick_o.motion = next_heading(npos, tmask, motion_i);
      tick_o.served = served;
    end
    tick_mask_o = tmask;
  end

  logic                         nop;
  logic [FLOOR_LIMIT-1:0][2:0]  amask;

  // stop insert, no-op when the idle car already stands there
  always_comb begin
    nop   = (floor_i == pos_i) && (motion_i == HEAD_IDLE);
    amask = mask_i;
    add_o = '0;
    if (!nop) begin
      amask[floor_i[FIDX_W-1:0]][kind_i] = 1'b1;
    end
    add_o.pos    = pos_i;
    add_o.nop    = nop;
    add_o.motion = (!nop && (motion_i == HEAD_IDLE)) ?
                   next_heading(pos_i, amask, HEAD_IDLE) : motion_i;
    add_mask_o   = amask;
  end

  logic [FLOOR_W-1:0] gap;
  logic               same_way;

  // hall call score, kind carries the call direction
  always_comb begin
    gap      = (pos_i > floor_i) ? pos_i - floor_i : floor_i - pos_i;
    same_way = (motion_i == kind_i) &&
               (((kind_i == HEAD_UP) && (pos_i <= floor_i)) ||
                ((kind_i == HEAD_DOWN) && (pos_i >= floor_i)));
    if (same_way) begin
      score_o = SCORE_W'(gap);
    end else if ((motion_i == HEAD_IDLE) && (mask_i == '0)) begin
      score_o = SCORE_W'(gap) + SCORE_W'(1);
    end else begin
      score_o = SCORE_W'(gap) + SCORE_W'(floors_i);
    end
  end

endmodule
`default_nettype wire

[rtl/multi_car_elevator_dispatcher.sv]
// A tick reads, steps and writes back each car in turn, one status per car; a hall
//   call scores every car before it adds the stop; a rejected request skips the RAM.
// Throughput is one request at a time, set by the car state RAM being read, updated
//   and written back per car, followed by a stop count and the output load.
// Reset (async, active low) clears control state and the per-car valid bits; a car
//   never written reads as ground floor, idle, no stops. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_car_elevator_dispatcher
// Elevator dispatcher with cost-based hall call assignment and LOOK stepping;
// car state lives in a RAM that is read, modified and written back per car.
// ----------------------------------------------------------------------------
module multi_car_elevator_dispatcher #(
  parameter int CAR_COUNT   = 3,
  parameter int FLOOR_LIMIT = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mcd_pkg::FIU_W-1:0]   cfg_wdata_i,
  mcd_req_if.sink                          req_i,
  mcd_rpt_if.source                        rpt_o
);
  import mcd_pkg::*;

  localparam int AW     = (CAR_COUNT > 1) ? $clog2(CAR_COUNT) : 1;
  localparam int MASK_W = 3 * FLOOR_LIMIT;
  localparam int REC_W  = FLOOR_W + 2 + MASK_W;
  localparam int NGRP   = (FLOOR_LIMIT + 3) / 4;
  localparam logic [CAR_W-1:0] LAST_CAR = CAR_W'(CAR_COUNT - 1);
  localparam logic [2:0]       CAR_LIM  = 3'(CAR_COUNT);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CALC, S_APPLY, S_CNT, S_EMIT
  } state_e;

  state_e                       state_q;
  logic [FIU_W-1:0]             floors_q;
  logic [1:0]                   type_q;
  logic [FLOOR_W-1:0]           floor_q;
  logic [1:0]                   dir_q;
  logic [CAR_W-1:0]             idx_q;
  logic [CAR_W-1:0]             car_q;
  logic                         rej_q;
  logic [SCORE_W-1:0]           best_q;
  logic [CAR_COUNT-1:0]         vld_q;
  logic                         rvld_q;
  logic [FLOOR_W-1:0]           rpos_q;
  logic [1:0]                   rmot_q;
  logic [FLOOR_LIMIT-1:0][2:0]  rmask_q;
  car_upd_t                     res_q;
  logic [FLOOR_LIMIT-1:0][2:0]  res_mask_q;
  logic [NGRP-1:0][3:0]         grp_q;
  logic [NGRP-1:0][3:0]         grp_d;

  // output register
  logic                         out_valid_q;
  logic                         out_kind_q;
  logic                         out_acc_q;
  logic                         out_nop_q;
  logic [CAR_W-1:0]             out_car_q;
  logic [FLOOR_W-1:0]           out_pos_q;
  logic [1:0]                   out_head_q;
  logic [2:0]                   out_served_q;
  logic [CNT_W-1:0]             out_cnt_q;
  logic                         out_last_q;

  // ram and car logic nets
  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [REC_W-1:0]             ram_wdata;
  logic [REC_W-1:0]             ram_rdata;
  logic [FLOOR_W-1:0]           mem_pos;
  logic [1:0]                   mem_mot;
  logic [FLOOR_LIMIT-1:0][2:0]  mem_mask;
  logic [FLOOR_W-1:0]           cl_pos;
  logic [1:0]                   cl_mot;
  logic [FLOOR_LIMIT-1:0][2:0]  cl_mask;
  logic [1:0]                   cl_kind;
  car_upd_t                     tick_upd;
  car_upd_t                     add_upd;
  logic [FLOOR_LIMIT-1:0][2:0]  tick_mask;
  logic [FLOOR_LIMIT-1:0][2:0]  add_mask;
  logic [SCORE_W-1:0]           score;

  logic                         req_fire;
  logic                         fl_ok;
  logic                         hall_ok;
  logic                         cabin_ok;
  logic                         out_load;
  logic [CNT_W-1:0]             cnt_sum;

  // request handshake and validation
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign fl_ok       = (FIU_W'(req_i.floor) < floors_q) &&
                       (FIU_W'(req_i.floor) < FIU_W'(FLOOR_LIMIT));
  assign hall_ok     = fl_ok && ((req_i.hall_direction == HEAD_UP) ||
                                 (req_i.hall_direction == HEAD_DOWN));
  assign cabin_ok    = fl_ok && (req_i.car_select < CAR_LIM);

  // car record from ram, reset value until the entry is first written
  assign mem_pos  = rvld_q ? ram_rdata[REC_W-1 -: FLOOR_W] : '0;
  assign mem_mot  = rvld_q ? ram_rdata[MASK_W+1 -: 2] : HEAD_IDLE;
  assign mem_mask = rvld_q ? ram_rdata[MASK_W-1:0] : '0;

  // car logic operand select
  assign cl_pos  = (state_q == S_APPLY) ? rpos_q  : mem_pos;
  assign cl_mot  = (state_q == S_APPLY) ? rmot_q  : mem_mot;
  assign cl_mask = (state_q == S_APPLY) ? rmask_q : mem_mask;
  assign cl_kind = (type_q == REQ_CABIN) ? KIND_CABIN : dir_q;

  // ram access
  assign ram_re    = (state_q == S_RD);
  assign ram_raddr = idx_q[AW-1:0];
  assign ram_we    = ((state_q == S_CALC) && (type_q == REQ_TICK)) || (state_q == S_APPLY);
  assign ram_waddr = (state_q == S_APPLY) ? car_q[AW-1:0] : idx_q[AW-1:0];
  assign ram_wdata = (state_q == S_APPLY) ? {add_upd.pos, add_upd.motion, add_mask} :
                                            {tick_upd.pos, tick_upd.motion, tick_mask};

  mcd_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAR_COUNT)
  ) u_car_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mcd_car_logic #(
    .FLOOR_LIMIT (FLOOR_LIMIT)
  ) u_car_logic (
    .pos_i       (cl_pos),
    .motion_i    (cl_mot),
    .mask_i      (cl_mask),
    .floor_i     (floor_q),
    .kind_i      (cl_kind),
    .floors_i    (floors_q),
    .tick_o      (tick_upd),
    .tick_mask_o (tick_mask),
    .add_o       (add_upd),
    .add_mask_o  (add_mask),
    .score_o     (score)
  );

  // pending stop count, first stage: per-group sums of four floors
  always_comb begin
    logic [NGRP*4-1:0][2:0] padded;
    logic [NGRP*4-1:0][1:0] fc;
    padded = '0;
    padded[FLOOR_LIMIT-1:0] = res_mask_q;
    for (int f = 0; f < NGRP * 4; f++) begin
      fc[f] = 2'(padded[f][0]) + 2'(padded[f][1]) + 2'(padded[f][2]);
    end
    for (int j = 0; j < NGRP; j++) begin
      grp_d[j] = 4'(fc[4*j]) + 4'(fc[4*j+1]) + 4'(fc[4*j+2]) + 4'(fc[4*j+3]);
    end
  end

  // pending stop count, second stage: add the group sums
  always_comb begin
    cnt_sum = '0;
    for (int j = 0; j < NGRP; j++) begin
      cnt_sum = cnt_sum + CNT_W'(grp_q[j]);
    end
  end

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || rpt_o.ready);

  // sequencer, car state write-back bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      floors_q     <= FIU_RESET;
      type_q       <= REQ_HALL;
      floor_q      <= '0;
      dir_q        <= HEAD_UP;
      idx_q        <= '0;
      car_q        <= '0;
      rej_q        <= 1'b0;
      best_q       <= '0;
      vld_q        <= '0;
      rvld_q       <= 1'b0;
      rpos_q       <= '0;
      rmot_q       <= HEAD_IDLE;
      rmask_q      <= '0;
      res_q        <= '0;
      res_mask_q   <= '0;
      grp_q        <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= RPT_ACK;
      out_acc_q    <= 1'b0;
      out_nop_q    <= 1'b0;
      out_car_q    <= '0;
      out_pos_q    <= '0;
      out_head_q   <= '0;
      out_served_q <= '0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // configuration write
      if (cfg_we_i) begin
        floors_q <= cfg_wdata_i;
      end

      // entry becomes valid on its first write-back
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end

      // output slot frees when the report is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rpt_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            type_q  <= req_i.req_type;
            floor_q <= req_i.floor;
            dir_q   <= req_i.hall_direction;
            rej_q   <= 1'b0;
            idx_q   <= '0;
            state_q <= S_RD;
            case (req_i.req_type)
              REQ_TICK: begin
              end
              REQ_HALL: begin
                if (!hall_ok) begin
                  rej_q   <= 1'b1;
                  state_q <= S_EMIT;
                end
              end
              REQ_CABIN: begin
                if (cabin_ok) begin
                  idx_q <= req_i.car_select[CAR_W-1:0];
                  car_q <= req_i.car_select[CAR_W-1:0];
                end else begin
                  rej_q   <= 1'b1;
                  state_q <= S_EMIT;
                end
              end
              default: begin
                rej_q   <= 1'b1;
                state_q <= S_EMIT;
              end
            endcase
          end
        end

        S_RD: begin
          rvld_q  <= vld_q[ram_raddr];
          state_q <= S_CALC;
        end

        S_CALC: begin
          case (type_q)
            REQ_TICK: begin
              res_q      <= tick_upd;
              res_mask_q <= tick_mask;
              car_q      <= idx_q;
              state_q    <= S_CNT;
            end
            REQ_HALL: begin
              // lowest score wins, ties stay with the lower car
              if ((idx_q == '0) || (score < best_q)) begin
                best_q  <= score;
                car_q   <= idx_q;
                rpos_q  <= mem_pos;
                rmot_q  <= mem_mot;
                rmask_q <= mem_mask;
              end
              if (idx_q == LAST_CAR) begin
                state_q <= S_APPLY;
              end else begin
                idx_q   <= idx_q + CAR_W'(1);
                state_q <= S_RD;
              end
            end
            REQ_CABIN: begin
              rpos_q  <= mem_pos;
              rmot_q  <= mem_mot;
              rmask_q <= mem_mask;
              state_q <= S_APPLY;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end

        S_APPLY: begin
          res_q      <= add_upd;
          res_mask_q <= add_mask;
          state_q    <= S_CNT;
        end

        S_CNT: begin
          grp_q   <= grp_d;
          state_q <= S_EMIT;
        end

        S_EMIT: begin
          if (out_load) begin
            if (rej_q) begin
              out_kind_q   <= RPT_ACK;
              out_acc_q    <= 1'b0;
              out_nop_q    <= 1'b0;
              out_car_q    <= '0;
              out_pos_q    <= '0;
              out_head_q   <= '0;
              out_served_q <= '0;
              out_cnt_q    <= '0;
              out_last_q   <= 1'b1;
            end else begin
              out_kind_q   <= (type_q == REQ_TICK) ? RPT_STATUS : RPT_ACK;
              out_acc_q    <= 1'b1;
              out_nop_q    <= (type_q == REQ_TICK) ? 1'b0 : res_q.nop;
              out_car_q    <= car_q;
              out_pos_q    <= res_q.pos;
              out_head_q   <= res_q.motion;
              out_served_q <= (type_q == REQ_TICK) ? res_q.served : 3'd0;
              out_cnt_q    <= cnt_sum;
              out_last_q   <= (type_q != REQ_TICK) || (idx_q == LAST_CAR);
            end
            // a tick walks on to the next car
            if (!rej_q && (type_q == REQ_TICK) && (idx_q != LAST_CAR)) begin
              idx_q   <= idx_q + CAR_W'(1);
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // report channel
  assign rpt_o.valid               = out_valid_q;
  assign rpt_o.report_kind         = out_kind_q;
  assign rpt_o.accepted            = out_acc_q;
  assign rpt_o.no_op               = out_nop_q;
  assign rpt_o.car_index           = out_car_q;
  assign rpt_o.car_floor_now       = out_pos_q;
  assign rpt_o.car_heading         = out_head_q;
  assign rpt_o.served_kinds        = out_served_q;
  assign rpt_o.pending_stops_count = out_cnt_q;
  assign rpt_o.last_of_run         = out_last_q;

`ifndef NO_ASSERTIONS
  // an emitted result is in the output register on the next cycle
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("emitted result not registered");

  // write-back only targets an existing car
  a_wb_car: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_waddr) < CAR_COUNT))
    else $error("write-back to a car out of range");

  // a car never moves past the top floor
  a_wb_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (32'(ram_wdata[REC_W-1 -: FLOOR_W]) < FLOOR_LIMIT))
    else $error("car floor out of range");

  // an invalid hall call skips the ram and goes straight to the acknowledge
  a_reject_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.req_type == REQ_HALL) && !hall_ok) |=>
      (state_q == S_EMIT) && rej_q)
    else $error("rejected hall call took the ram path");
`endif

endmodule
`default_nettype wire

[test/multi_car_elevator_dispatcher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_car_elevator_dispatcher_tb
// Drives hall calls, cabin calls and ticks into the dispatcher and checks every
// acknowledge and car status against a cycle-free model of the cars kept here.
// A directed table comes first, then random traffic under several floor counts.
// ----------------------------------------------------------------------------
module multi_car_elevator_dispatcher_tb;
  import mcd_pkg::*;

  localparam int CARS        = 3;
  localparam int FLOORS      = 16;
  localparam int SETTLE      = 4 * CARS + 4;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PRINT_LIMIT = 40;

  // codes the package has no name for
  localparam logic [1:0] REQ_BAD        = 2'd3;
  localparam logic [1:0] DIR_BAD        = 2'd3;
  localparam int         KIND_HALL_UP   = 0;
  localparam int         KIND_HALL_DOWN = 1;
  localparam logic [2:0] SERVE_UP       = 3'b001;
  localparam logic [2:0] SERVE_DOWN     = 3'b010;
  localparam logic [2:0] SERVE_CABIN    = 3'b100;

  typedef struct packed {
    logic       kind;
    logic       acc;
    logic       nop;
    logic [1:0] car;
    logic [3:0] flr;
    logic [1:0] head;
    logic [2:0] served;
    logic [5:0] pend;
    logic       last;
  } report_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] flr;
    logic [1:0] dir;
    logic [2:0] sel;
    logic       typed;
    report_t    want;
  } request_t;

  localparam report_t REFUSED =
    '{RPT_ACK, 1'b0, 1'b0, 2'd0, 4'd0, 2'd0, 3'd0, 6'd0, 1'b1};
  localparam report_t NOP_CAR0 =
    '{RPT_ACK, 1'b1, 1'b1, 2'd0, 4'd0, HEAD_IDLE, 3'd0, 6'd0, 1'b1};
  localparam report_t NOP_CAR2 =
    '{RPT_ACK, 1'b1, 1'b1, 2'd2, 4'd0, HEAD_IDLE, 3'd0, 6'd0, 1'b1};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [FIU_W-1:0] cfg_wdata = '0;
  logic             sink_ready = 1'b0;

  mcd_req_if req_ch ();
  mcd_rpt_if rpt_ch ();

  assign rpt_ch.ready = sink_ready;

  multi_car_elevator_dispatcher #(
    .CAR_COUNT   (CARS),
    .FLOOR_LIMIT (FLOORS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rpt_o       (rpt_ch)
  );

  // car state as the dispatcher should hold it
  logic [3:0]       car_floor [CARS];
  logic [1:0]       car_dir   [CARS];
  logic [47:0]      car_stops [CARS];
  logic [FIU_W-1:0] floors_cfg = FIU_RESET;

  report_t  step_reports [$];
  report_t  awaited_reports [$];
  request_t plan [$];

  int  cycle_count = 0;
  int  misses = 0;
  int  requests_sent = 0;
  int  reports_seen = 0;
  int  hold_rpt = 0;
  bit  calm = 1'b0;
  report_t seen;
  report_t want;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic log_miss(string what);
    misses++;
    if (misses <= PRINT_LIMIT) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(string name, logic [5:0] got, logic [5:0] exp_val);
    if (got !== exp_val) log_miss($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  // LOOK heading choice from the stops above and below the car
  function automatic void pick_heading(int c);
    logic [63:0] m;
    int          p;
    bit          above;
    bit          below;
    m = 64'(car_stops[c]);
    p = car_floor[c];
    above = (m >> (3 * (p + 1))) != 64'd0;
    below = (m & ((64'd1 << (3 * p)) - 64'd1)) != 64'd0;
    if (m == 64'd0) begin
      car_dir[c] = HEAD_IDLE;
    end else if (car_dir[c] == HEAD_DOWN) begin
      car_dir[c] = below ? HEAD_DOWN : (above ? HEAD_UP : HEAD_IDLE);
    end else begin
      car_dir[c] = above ? HEAD_UP : (below ? HEAD_DOWN : HEAD_IDLE);
    end
  endfunction

  // returns 1 when the stop is the idle car's own floor
  function automatic bit place_stop(int c, int fl, int kind);
    if (fl == car_floor[c] && car_dir[c] == HEAD_IDLE) return 1'b1;
    car_stops[c][3 * fl + kind] = 1'b1;
    if (car_dir[c] == HEAD_IDLE) pick_heading(c);
    return 1'b0;
  endfunction

  function automatic int call_cost(int c, int fl, logic [1:0] dir);
    int p;
    int span;
    p = car_floor[c];
    span = (p > fl) ? p - fl : fl - p;
    if (car_dir[c] == dir && ((dir == HEAD_UP && p <= fl) || (dir == HEAD_DOWN && p >= fl)))
      return span;
    if (car_dir[c] == HEAD_IDLE && car_stops[c] == '0) return span + 1;
    return span + int'(floors_cfg);
  endfunction

  function automatic report_t car_report(logic kind, logic nop, int c, logic [2:0] served,
                                         logic last);
    report_t r;
    r.kind   = kind;
    r.acc    = 1'b1;
    r.nop    = nop;
    r.car    = 2'(c);
    r.flr    = car_floor[c];
    r.head   = car_dir[c];
    r.served = served;
    r.pend   = 6'($countones(car_stops[c]));
    r.last   = last;
    return r;
  endfunction

  // apply one request to the car state, leaving its reports in step_reports
  function automatic void dispatch_request(request_t s);
    bit         fl_ok;
    bit         nop;
    int         best;
    int         best_cost;
    int         cost;
    logic [2:0] here;
    logic [2:0] served;
    step_reports.delete();
    fl_ok = s.flr < floors_cfg;
    case (s.op)
      REQ_TICK: begin
        for (int c = 0; c < CARS; c++) begin
          served = '0;
          if (car_stops[c] == '0) begin
            car_dir[c] = HEAD_IDLE;
          end else begin
            if (car_dir[c] == HEAD_UP && car_floor[c] < FLOORS - 1) car_floor[c]++;
            else if (car_dir[c] == HEAD_DOWN && car_floor[c] > 0) car_floor[c]--;
            here = 3'(car_stops[c] >> (3 * car_floor[c]));
            served = here & SERVE_CABIN;
            if (car_dir[c] == HEAD_UP) served |= here & SERVE_UP;
            if (car_dir[c] == HEAD_DOWN) served |= here & SERVE_DOWN;
            car_stops[c] &= ~(48'(served) << (3 * car_floor[c]));
            pick_heading(c);
          end
          step_reports = {step_reports,
                          car_report(RPT_STATUS, 1'b0, c, served, c == CARS - 1)};
        end
      end
      REQ_HALL: begin
        if (!fl_ok || s.dir > HEAD_DOWN) begin
          step_reports = {step_reports, REFUSED};
        end else begin
          best = 0;
          best_cost = 32'h7fffffff;
          for (int c = 0; c < CARS; c++) begin
            cost = call_cost(c, s.flr, s.dir);
            if (cost < best_cost) begin
              best_cost = cost;
              best = c;
            end
          end
          nop = place_stop(best, s.flr,
                           (s.dir == HEAD_UP) ? KIND_HALL_UP : KIND_HALL_DOWN);
          step_reports = {step_reports, car_report(RPT_ACK, nop, best, 3'd0, 1'b1)};
        end
      end
      REQ_CABIN: begin
        if (s.sel >= CARS || !fl_ok) begin
          step_reports = {step_reports, REFUSED};
        end else begin
          nop = place_stop(s.sel, s.flr, int'(KIND_CABIN));
          step_reports = {step_reports, car_report(RPT_ACK, nop, s.sel, 3'd0, 1'b1)};
        end
      end
      default: begin
        step_reports = {step_reports, REFUSED};
      end
    endcase
  endfunction

  function automatic request_t row(logic [1:0] op, logic [3:0] flr, logic [1:0] dir,
                                   logic [2:0] sel, logic typed, report_t exp_rpt);
    request_t s;
    s.op    = op;
    s.flr   = flr;
    s.dir   = dir;
    s.sel   = sel;
    s.typed = typed;
    s.want  = exp_rpt;
    return s;
  endfunction

  // mostly valid calls and ticks, some raw noise
  function automatic request_t random_request();
    request_t s;
    int       roll;
    s = '0;
    s.op  = 2'($urandom);
    s.flr = 4'($urandom);
    s.dir = 2'($urandom);
    s.sel = 3'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return s;
    end else if (roll < 50) begin
      s.op = REQ_TICK;
    end else if (roll < 80) begin
      s.op  = REQ_HALL;
      s.flr = 4'($urandom_range(0, int'(floors_cfg) - 1));
      s.dir = $urandom_range(0, 1) ? HEAD_DOWN : HEAD_UP;
    end else begin
      s.op  = REQ_CABIN;
      s.flr = 4'($urandom_range(0, int'(floors_cfg) - 1));
      s.sel = 3'($urandom_range(0, CARS - 1));
    end
    return s;
  endfunction

  // present one request, holding valid high into the next one unless a gap is drawn
  task automatic offer(request_t s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= s.op;
    req_ch.floor          <= s.flr;
    req_ch.hall_direction <= s.dir;
    req_ch.car_select     <= s.sel;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    dispatch_request(s);
    if (s.typed) begin
      awaited_reports = {awaited_reports, s.want};
    end else begin
      awaited_reports = {awaited_reports, step_reports};
    end
    requests_sent++;
  endtask

  // stop sending and let every outstanding report come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_floors(logic [FIU_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    floors_cfg = value;
  endtask

  // report sink with random stall bursts
  always @(posedge clk_i) begin
    if (hold_rpt > 0) begin
      hold_rpt   <= hold_rpt - 1;
      sink_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_rpt   <= $urandom_range(1, 16) - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // compare each report with the oldest one outstanding
  always @(posedge clk_i) begin
    if (rst_ni && rpt_ch.valid === 1'b1 && sink_ready) begin
      seen = {rpt_ch.report_kind, rpt_ch.accepted, rpt_ch.no_op, rpt_ch.car_index,
              rpt_ch.car_floor_now, rpt_ch.car_heading, rpt_ch.served_kinds,
              rpt_ch.pending_stops_count, rpt_ch.last_of_run};
      reports_seen++;
      if (awaited_reports.size() == 0) begin
        log_miss("report with none outstanding");
      end else begin
        want = awaited_reports.pop_front();
        check_field("report_kind", 6'(seen.kind), 6'(want.kind));
        check_field("accepted", 6'(seen.acc), 6'(want.acc));
        check_field("no_op", 6'(seen.nop), 6'(want.nop));
        check_field("car_index", 6'(seen.car), 6'(want.car));
        check_field("car_floor_now", 6'(seen.flr), 6'(want.flr));
        check_field("car_heading", 6'(seen.head), 6'(want.head));
        check_field("served_kinds", 6'(seen.served), 6'(want.served));
        check_field("pending_stops_count", seen.pend, want.pend);
        check_field("last_of_run", 6'(seen.last), 6'(want.last));
      end
    end
  end

  initial begin
    logic [FIU_W-1:0] phase_floors [4];
    int               phase_items [4];

    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_HALL;
    req_ch.floor          <= '0;
    req_ch.hall_direction <= HEAD_UP;
    req_ch.car_select     <= '0;
    for (int c = 0; c < CARS; c++) begin
      car_floor[c] = '0;
      car_dir[c]   = HEAD_IDLE;
      car_stops[c] = '0;
    end

    // directed table, run under the reset floor count of ten
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    // stops at the idle cars' own floor
    plan = {plan, row(REQ_HALL, 4'd0, HEAD_UP, 3'd0, 1'b1, NOP_CAR0)};
    plan = {plan, row(REQ_CABIN, 4'd0, HEAD_UP, 3'd2, 1'b1, NOP_CAR2)};
    // rejected requests
    plan = {plan, row(REQ_HALL, 4'd10, HEAD_UP, 3'd0, 1'b1, REFUSED)};
    plan = {plan, row(REQ_HALL, 4'd15, HEAD_DOWN, 3'd7, 1'b1, REFUSED)};
    plan = {plan, row(REQ_HALL, 4'd3, HEAD_IDLE, 3'd0, 1'b1, REFUSED)};
    plan = {plan, row(REQ_HALL, 4'd3, DIR_BAD, 3'd0, 1'b1, REFUSED)};
    plan = {plan, row(REQ_CABIN, 4'd4, HEAD_UP, 3'd3, 1'b1, REFUSED)};
    plan = {plan, row(REQ_CABIN, 4'd4, HEAD_UP, 3'd7, 1'b1, REFUSED)};
    plan = {plan, row(REQ_BAD, 4'd5, DIR_BAD, 3'd0, 1'b1, REFUSED)};
    plan = {plan, row(REQ_CABIN, 4'd15, HEAD_UP, 3'd0, 1'b1, REFUSED)};
    // top served floor, then hall calls scored against a moving car
    plan = {plan, row(REQ_CABIN, 4'd9, HEAD_UP, 3'd2, 1'b0, '0)};
    plan = {plan, row(REQ_HALL, 4'd5, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_HALL, 4'd3, HEAD_DOWN, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_CABIN, 4'd0, HEAD_UP, 3'd1, 1'b0, '0)};
    // car 0 arrives going up at a down call and is left stranded
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_CABIN, 4'd3, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_CABIN, 4'd1, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};
    plan = {plan, row(REQ_TICK, 4'd0, HEAD_UP, 3'd0, 1'b0, '0)};

    phase_floors[0] = 5'd16;
    phase_floors[1] = 5'd2;
    phase_floors[2] = 5'($urandom_range(3, 15));
    phase_floors[3] = 5'd16;
    phase_items[0]  = 26;
    phase_items[1]  = 16;
    phase_items[2]  = 20;
    phase_items[3]  = 14;

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer(plan[i]);
    drain();

    // random phases, the last one without idling on either side
    for (int ph = 0; ph < 4; ph++) begin
      set_floors(phase_floors[ph]);
      calm = (ph == 3);
      repeat (phase_items[ph]) offer(random_request());
      drain();
    end

    $display("tb: %0d requests sent, %0d reports checked, floor counts 10 16 2 %0d 16",
             requests_sent, reports_seen, phase_floors[2]);
    $display("tb: covered hall and cabin calls, ticks, rejects, own-floor stops, stranding");
    if (misses == 0 && awaited_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mcd_pkg.sv
rtl/mcd_req_if.sv
rtl/mcd_rpt_if.sv
rtl/mcd_ram.sv
rtl/mcd_car_logic.sv
rtl/multi_car_elevator_dispatcher.sv
test/multi_car_elevator_dispatcher_tb.sv
